[design/pfib_pkg.sv]
// shared constants for the planar float to interleaved byte converter
// no dependencies
`timescale 1ns / 1ps
package pfib_pkg;
    localparam int unsigned MAX_PIXELS = 16777216;
    localparam int unsigned MAX_BANDS  = 16;
    localparam int unsigned PIX_CNT_W  = 25;
    localparam int unsigned BAND_CNT_W = 5;
    localparam int unsigned PIX_POS_W  = 24;
    localparam int unsigned BAND_POS_W = 4;
    localparam int unsigned INDEX_W    = 28;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COUNT   = 2'd0,
        CFG_BAND_COUNT    = 2'd1,
        CFG_SOURCE_FORMAT = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [INDEX_W-1:0] dest_index;
        logic [7:0]         pixel_value;
        logic               image_done;
    } t_result;
endpackage

[design/pfib_cvt.sv]
// float sample to byte: clamp to [0,1], scale by 255 in fp32, round to nearest even
// does not use pfib_pkg (no package items needed)
`timescale 1ns / 1ps
module pfib_cvt (
    input  logic [31:0] i_sample,
    input  logic        i_fp16,
    output logic [7:0]  o_byte
);
    logic        nan, neg, big, tiny;
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [31:0] prod, prod_n;
    logic [23:0] keep;
    logic        g1, s1, sh8;
    logic [24:0] rnd;
    logic [8:0]  t;
    logic [4:0]  t5, t5m1;
    logic [24:0] n, below;
    logic        g2, s2;
    logic [25:0] n_r;

    always_comb begin
        if (i_fp16) begin
            nan  = (i_sample[14:10] == 5'h1F) && (i_sample[9:0] != 10'd0);
            neg  = i_sample[15];
            big  = i_sample[15:0] >= 16'h3C00;
            tiny = i_sample[14:10] == 5'd0;
            expo = {3'd0, i_sample[14:10]} + 8'd112;
            mant = {i_sample[9:0], 13'd0};
        end else begin
            nan  = (i_sample[30:23] == 8'hFF) && (i_sample[22:0] != 23'd0);
            neg  = i_sample[31];
            big  = i_sample >= 32'h3F800000;
            tiny = i_sample[30:23] == 8'd0;
            expo = i_sample[30:23];
            mant = i_sample[22:0];
        end

        // exact product, then round to 24 significant bits
        prod   = {8'd0, 1'b1, mant} * 32'd255;
        sh8    = prod[31];
        prod_n = sh8 ? prod : {prod[30:0], 1'b0};
        keep   = prod_n[31:8];
        g1     = prod_n[7];
        s1     = |prod_n[6:0];
        rnd    = {1'b0, keep} + {24'd0, (g1 && (s1 || keep[0]))};

        // integer rounding: shift right by t
        t      = 9'd150 - {1'b0, expo} - (sh8 ? 9'd8 : 9'd7);
        t5     = t[4:0];
        t5m1   = t5 - 5'd1;
        n      = rnd >> t5;
        below  = rnd & ((25'd1 << t5m1) - 25'd1);
        g2     = rnd[t5m1];
        s2     = |below;
        n_r    = {1'b0, n} + {25'd0, (g2 && (s2 || n[0]))};

        if (nan || neg)           o_byte = 8'd0;
        else if (big)             o_byte = 8'd255;
        else if (tiny || t >= 9'd26) o_byte = 8'd0;
        else if (n_r > 26'd255)   o_byte = 8'd255;
        else                      o_byte = n_r[7:0];
    end
endmodule

[design/planar_float_to_interleaved_byte.sv]
// top level: planar float samples in, interleaved bytes with destination index out
// depends on pfib_pkg and pfib_cvt
`timescale 1ns / 1ps
// usage
//   input channel: i_valid / o_stall carry one planar sample per request in
//   plane order (all pixels of band 0, then band 1, ...)
//   output channel: o_valid / i_stall carry one result per request: the byte,
//   its interleaved index pixel*bands+band, and a flag on the last sample
//   config: i_cfg_valid / o_cfg_ready (always ready), index 0 pixel count,
//   1 band count, 2 source format (0 fp32, 1 fp16 in low bits); write only
//   while idle, other indexes are dropped
// an accepted request enters the output register, or the skid while it is held;
// one request per cycle unless stalled, set by the single conversion stage
// a skid register behind the output register lets one more request in while
// the receiver stalls; o_stall rises only when both are full
// reset clears both valid flags, the pixel and band positions and loads the
// register defaults (1 pixel, 3 bands, fp32)
module planar_float_to_interleaved_byte (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_sample_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [pfib_pkg::INDEX_W-1:0] o_dest_index,
    output logic [7:0]  o_pixel_value,
    output logic        o_image_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pfib_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    // configuration registers
    logic [pfib_pkg::PIX_CNT_W-1:0]  r_pix_cnt;
    logic [pfib_pkg::BAND_CNT_W-1:0] r_band_cnt;
    logic                            r_fmt;
    // position counters
    logic [pfib_pkg::PIX_POS_W-1:0]  r_pix_pos, n_pix_pos;
    logic [pfib_pkg::BAND_POS_W-1:0] r_band_pos, n_band_pos;
    // output and skid stages
    pfib_pkg::t_result r_out, r_skid, n_res;
    logic r_out_v, r_skid_v;

    logic in_acc, out_acc;
    logic [pfib_pkg::PIX_CNT_W-1:0]  pixels;
    logic [pfib_pkg::BAND_CNT_W-1:0] bands;
    logic last_pixel, last_band;
    logic [7:0] byte_val;
    logic [pfib_pkg::PIX_POS_W+pfib_pkg::BAND_CNT_W-1:0] idx_full;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_v;
    assign o_valid     = r_out_v;
    assign in_acc      = i_valid && !r_skid_v;
    assign out_acc     = r_out_v && !i_stall;

    pfib_cvt u_cvt (
        .i_sample (i_sample_bits),
        .i_fp16   (r_fmt),
        .o_byte   (byte_val)
    );

    always_comb begin
        // counts saturated into their legal range
        if (r_pix_cnt == '0)
            pixels = pfib_pkg::PIX_CNT_W'(1);
        else if (r_pix_cnt > pfib_pkg::PIX_CNT_W'(pfib_pkg::MAX_PIXELS))
            pixels = pfib_pkg::PIX_CNT_W'(pfib_pkg::MAX_PIXELS);
        else
            pixels = r_pix_cnt;
        if (r_band_cnt == '0)
            bands = pfib_pkg::BAND_CNT_W'(1);
        else if (r_band_cnt > pfib_pkg::BAND_CNT_W'(pfib_pkg::MAX_BANDS))
            bands = pfib_pkg::BAND_CNT_W'(pfib_pkg::MAX_BANDS);
        else
            bands = r_band_cnt;

        last_pixel = ({1'b0, r_pix_pos} + 25'd1) >= pixels;
        last_band  = ({1'b0, r_band_pos} + 5'd1) >= bands;

        idx_full = r_pix_pos * bands + {25'd0, r_band_pos};
        n_res.dest_index  = idx_full[pfib_pkg::INDEX_W-1:0];
        n_res.pixel_value = byte_val;
        n_res.image_done  = last_pixel && last_band;

        if (last_pixel) begin
            n_pix_pos  = '0;
            n_band_pos = last_band ? '0 : r_band_pos + 4'd1;
        end else begin
            n_pix_pos  = r_pix_pos + 24'd1;
            n_band_pos = r_band_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_cnt  <= pfib_pkg::PIX_CNT_W'(1);
            r_band_cnt <= pfib_pkg::BAND_CNT_W'(3);
            r_fmt      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (pfib_pkg::t_cfg_idx'(i_cfg_index))
                pfib_pkg::CFG_PIXEL_COUNT:   r_pix_cnt  <= i_cfg_data[pfib_pkg::PIX_CNT_W-1:0];
                pfib_pkg::CFG_BAND_COUNT:    r_band_cnt <= i_cfg_data[pfib_pkg::BAND_CNT_W-1:0];
                pfib_pkg::CFG_SOURCE_FORMAT: r_fmt      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // positions advance once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_pos  <= '0;
            r_band_pos <= '0;
        end else if (in_acc) begin
            r_pix_pos  <= n_pix_pos;
            r_band_pos <= n_band_pos;
        end
    end

    // output register with skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || out_acc) begin
                r_out_v  <= r_skid_v || in_acc;
                r_skid_v <= 1'b0;
            end else if (in_acc) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || out_acc) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end
        if (in_acc && r_out_v && !out_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_dest_index  = r_out.dest_index;
    assign o_pixel_value = r_out.pixel_value;
    assign o_image_done  = r_out.image_done;

    // skid only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds data while output register is empty");

    // after an accepted request the output register is valid in the next cycle
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_v)
        else $error("accepted request lost");

    // request taken while output is stalled goes to skid
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_out_v && i_stall) |=> r_skid_v)
        else $error("request not parked in skid during stall");
endmodule

[tb/planar_float_to_interleaved_byte_tb.sv]
// self-checking testbench for planar_float_to_interleaved_byte: exact byte and index prediction
// depends on pfib_pkg and the converter rtl
`timescale 1ns / 1ps
module planar_float_to_interleaved_byte_tb;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [31:0]        i_sample_bits = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [pfib_pkg::INDEX_W-1:0] o_dest_index;
    logic [7:0]         o_pixel_value;
    logic               o_image_done;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [pfib_pkg::CFG_IDX_W-1:0] i_cfg_index = pfib_pkg::CFG_PIXEL_COUNT;
    logic [31:0]        i_cfg_data = '0;

    planar_float_to_interleaved_byte uut (.*);

    always #1 i_clk = ~i_clk;

    // samples waiting to be sent and bytes expected back
    logic [31:0]       sample_queue[$];
    pfib_pkg::t_result byte_queue[$];

    // predictor copy of registers and position counters
    logic [pfib_pkg::PIX_CNT_W-1:0]  pix_cnt_reg;
    logic [pfib_pkg::BAND_CNT_W-1:0] band_cnt_reg;
    logic                            fp16_mode;
    logic [pfib_pkg::PIX_POS_W-1:0]  pix_pos;
    logic [pfib_pkg::BAND_POS_W-1:0] band_pos;

    int  error_count = 0;
    bit  took;
    bit  hold_send = 1'b0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  stall_pct = 0;
    bit  long_hold_start = 1'b0;
    int  long_hold_cnt = 0;

    // shift right with round to nearest, ties to even
    function automatic longint unsigned rne_shift(longint unsigned q, int s);
        longint unsigned ip, rem, half;
        if (s <= 0) return q;
        if (s > 40) return 0;
        ip   = q >> s;
        rem  = q & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && ip[0])) ip++;
        return ip;
    endfunction

    // sig * 2^e times 255, rounded to fp32 then to an integer byte
    function automatic logic [7:0] scale_to_byte(longint unsigned sig, int e);
        longint unsigned q, v;
        int nbits;
        q = sig * 255;
        nbits = 0;
        for (int k = 0; k < 40; k++) if (q >> k) nbits = k + 1;
        // fp32 product keeps 24 significant bits
        if (nbits > 24) begin
            q = rne_shift(q, nbits - 24);
            e = e + nbits - 24;
        end
        v = (e >= 0) ? (q << e) : rne_shift(q, -e);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] sample_to_byte(logic [31:0] b, logic half);
        logic [4:0] e16;
        if (!half) begin
            if (b[30:23] == 8'hFF && b[22:0] != 0) return 8'd0;
            if (b[31]) return 8'd0;
            if (b >= 32'h3F80_0000) return 8'd255;
            if (b[30:23] == 0) return scale_to_byte(b[22:0], -149);
            return scale_to_byte({1'b1, b[22:0]}, int'(b[30:23]) - 150);
        end
        e16 = b[14:10];
        if (e16 == 5'h1F && b[9:0] != 0) return 8'd0;
        if (b[15]) return 8'd0;
        if (b[15:0] >= 16'h3C00) return 8'd255;
        if (e16 == 0) return scale_to_byte(b[9:0], -24);
        return scale_to_byte({1'b1, b[9:0]}, int'(e16) - 25);
    endfunction

    // accepted requests: predict, register writes, and result checking
    always @(posedge i_clk) begin
        pfib_pkg::t_result exp_r, got;
        int unsigned pixels, bands;
        bit last_pix, last_band;
        took = i_rst_n && i_valid && !o_stall;
        if (!i_rst_n) begin
            pix_cnt_reg  = 1;
            band_cnt_reg = 3;
            fp16_mode    = 1'b0;
            pix_pos      = '0;
            band_pos     = '0;
        end else begin
            if (took) begin
                // counts saturate to their legal range, zero counts as one
                pixels = (pix_cnt_reg == 0) ? 1 :
                         (pix_cnt_reg > pfib_pkg::MAX_PIXELS) ? pfib_pkg::MAX_PIXELS
                                                              : pix_cnt_reg;
                bands  = (band_cnt_reg == 0) ? 1 :
                         (band_cnt_reg > pfib_pkg::MAX_BANDS) ? pfib_pkg::MAX_BANDS
                                                              : band_cnt_reg;
                last_pix  = (pix_pos + 1) >= pixels;
                last_band = (band_pos + 1) >= bands;
                exp_r.dest_index  = pfib_pkg::INDEX_W'(pix_pos * bands + band_pos);
                exp_r.pixel_value = sample_to_byte(i_sample_bits, fp16_mode);
                exp_r.image_done  = last_pix && last_band;
                byte_queue.push_back(exp_r);
                if (last_pix) begin
                    pix_pos  = '0;
                    band_pos = last_band ? '0 : band_pos + 1'b1;
                end else begin
                    pix_pos = pix_pos + 1'b1;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (pfib_pkg::t_cfg_idx'(i_cfg_index))
                    pfib_pkg::CFG_PIXEL_COUNT:
                        pix_cnt_reg  = i_cfg_data[pfib_pkg::PIX_CNT_W-1:0];
                    pfib_pkg::CFG_BAND_COUNT:
                        band_cnt_reg = i_cfg_data[pfib_pkg::BAND_CNT_W-1:0];
                    pfib_pkg::CFG_SOURCE_FORMAT:
                        fp16_mode    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (byte_queue.size() == 0) begin
                    $error("result with nothing expected: index %0d", o_dest_index);
                    error_count++;
                end else begin
                    got = byte_queue.pop_front();
                    if (o_dest_index !== got.dest_index) begin
                        $error("dest_index expected %0d actual %0d", got.dest_index,
                               o_dest_index);
                        error_count++;
                    end
                    if (o_pixel_value !== got.pixel_value) begin
                        $error("pixel_value expected %0d actual %0d", got.pixel_value,
                               o_pixel_value);
                        error_count++;
                    end
                    if (o_image_done !== got.image_done) begin
                        $error("image_done expected %0b actual %0b", got.image_done,
                               o_image_done);
                        error_count++;
                    end
                end
            end
        end
    end

    // sender: bursts of requests with random gaps in between
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (!hold_send && sample_queue.size() != 0) begin
                i_sample_bits <= sample_queue.pop_front();
                i_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall pattern plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (long_hold_start) begin
            long_hold_cnt = 300;
            long_hold_start = 1'b0;
        end
        if (long_hold_cnt > 0) begin
            long_hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic write_reg(pfib_pkg::t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_image(logic [31:0] pixels, logic [31:0] bands, logic half);
        write_reg(pfib_pkg::CFG_PIXEL_COUNT, pixels);
        write_reg(pfib_pkg::CFG_BAND_COUNT, bands);
        write_reg(pfib_pkg::CFG_SOURCE_FORMAT, {31'd0, half});
    endtask

    // wait until the pipe has drained completely
    task automatic drain();
        while (sample_queue.size() != 0 || i_valid || byte_queue.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // random sample, mostly inside [0,1) where the rounding matters
    function automatic logic [31:0] rand_sample(logic half);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1: return r;
            2:    return half ? {r[31:16], 16'h3C00 - r[3:0]} : 32'h3F80_0000 - r[7:0];
            default: return half ? {r[31:16], 16'($urandom_range(0, 16'h3BFF))}
                                 : $urandom_range(0, 32'h3F7F_FFFF);
        endcase
    endfunction

    task automatic send_random(int n, logic half);
        for (int k = 0; k < n; k++) sample_queue.push_back(rand_sample(half));
    endtask

    initial begin
        logic [31:0] fp32_specials[14];
        logic [31:0] fp16_specials[10];
        fp32_specials = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F80_0000,
                          32'hFF80_0000, 32'h7FC0_0001, 32'h7F80_0001, 32'h3F00_0000,
                          32'h0000_0001, 32'h007F_FFFF, 32'h3F7F_FFFF, 32'h3B80_8081,
                          32'h4F00_0000, 32'hFFFF_FFFF};
        fp16_specials = '{32'h0000_3C00, 32'h0000_3BFF, 32'hFFFF_7C00, 32'h0000_7C01,
                          32'h0000_FC00, 32'h0000_8000, 32'hABCD_0001, 32'h0000_03FF,
                          32'h1234_3800, 32'h0000_0000};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: 1 pixel, 3 bands, fp32 special values
        stall_pct = 0;
        foreach (fp32_specials[k])
            sample_queue.push_back(fp32_specials[k]);
        drain();

        // zero counts act as one; fp16 special values with junk in the upper half
        set_image(0, 0, 1'b1);
        write_reg(pfib_pkg::CFG_UNUSED, 32'hFFFF_FFFF);
        foreach (fp16_specials[k])
            sample_queue.push_back(fp16_specials[k]);
        drain();

        // oversize counts saturate, then the largest legal counts
        stall_pct = 30;
        set_image(32'h01FF_FFFF, 31, 1'b0);
        send_random(60, 1'b0);
        drain();
        set_image(pfib_pkg::MAX_PIXELS, pfib_pkg::MAX_BANDS, 1'b1);
        send_random(60, 1'b1);
        drain();

        // shrink the image mid-way so the positions wrap early
        set_image(3, 2, 1'b0);
        send_random(2, 1'b0);
        drain();

        // long receiver hold-off while the sender keeps offering
        set_image(5, 16, 1'b0);
        send_random(200, 1'b0);
        long_hold_start = 1'b1;
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            logic half;
            half = $urandom_range(0, 1);
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
            set_image($urandom_range(1, 20), $urandom_range(1, 16), half);
            send_random(60, half);
            // sender stops until all results are back, then resumes
            hold_send = 1'b1;
            while (i_valid || byte_queue.size() != 0) @(posedge i_clk);
            hold_send = 1'b0;
            send_random(65, half);
            drain();
        end

        set_image(1, 1, 1'b0);
        send_random(40, 1'b0);
        drain();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

[sim.f]
design/pfib_pkg.sv
design/pfib_cvt.sv
design/planar_float_to_interleaved_byte.sv
tb/planar_float_to_interleaved_byte_tb.sv
